[hw/rtl/sorted_priority_queue_macros.svh]
// Assertion macros for the sorted priority queue checker.
// Each macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication.
`define SPQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sorted_priority_queue: same-cycle check failed");

// Next-cycle implication.
`define SPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sorted_priority_queue: next-cycle check failed");

`endif

[hw/rtl/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg
// Types, codes and sizes shared by the sorted priority queue modules.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH   = 16;
    localparam int FILL_W  = $clog2(DEPTH + 1);
    localparam int VALUE_W = 16;
    localparam int PRIO_W  = 4;
    localparam int COUNT_W = 5;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    localparam logic [1:0] STATUS_DONE         = 2'd0;
    localparam logic [1:0] STATUS_INSERT_FULL  = 2'd1;
    localparam logic [1:0] STATUS_REMOVE_EMPTY = 2'd2;

    localparam logic [1:0] OP_HOLD   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    typedef struct packed {
        logic                      mode;
        logic signed [VALUE_W-1:0] value;
        logic        [PRIO_W-1:0]  prio;
    } t_in;

    typedef struct packed {
        logic        [1:0]         status;
        logic signed [VALUE_W-1:0] out_value;
        logic        [PRIO_W-1:0]  out_prio;
        logic        [COUNT_W-1:0] count;
        logic                      is_empty;
        logic                      is_full;
    } t_out;

    // Command broadcast to every cell.
    typedef struct packed {
        logic        [1:0]         op;
        logic signed [VALUE_W-1:0] value;
        logic        [PRIO_W-1:0]  prio;
    } t_cmd;

    // What a cell shows its neighbors.
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic        [PRIO_W-1:0]  prio;
        logic                      ge;
    } t_link;

endpackage

[hw/rtl/sorted_priority_queue.sv]
// The result of a transaction is registered and valid in the cycle after acceptance.
// One transaction per cycle unless output stalls; all cells compare and shift at once.
// The input is taken whenever the output register is empty or being drained.
// Reset (synchronous, active low) empties the queue and the output register;
// entry storage is not cleared, only the fill count.
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue held in a chain of cells sorted by descending
// priority, with arrival order kept among equal priorities.
// ----------------------------------------------------------------------------
module sorted_priority_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  spq_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output spq_pkg::t_out o_out_data
);
    import spq_pkg::*;

    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] n_fill;
    logic              r_out_valid;
    t_out              r_out_data;
    t_out              n_out_data;
    logic              w_accept;
    logic              w_full;
    logic              w_empty;
    t_cmd              w_cmd;
    t_link             w_link [DEPTH];

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_full     = (r_fill == FILL_W'(DEPTH));
    assign w_empty    = (r_fill == '0);

    always_comb begin
        w_cmd.op    = OP_HOLD;
        w_cmd.value = i_in_data.value;
        w_cmd.prio  = i_in_data.prio;
        n_fill      = r_fill;
        n_out_data  = '0;
        if (i_in_data.mode == MODE_INSERT) begin
            if (w_full) begin
                n_out_data.status = STATUS_INSERT_FULL;
            end else begin
                w_cmd.op = w_accept ? OP_INSERT : OP_HOLD;
                n_fill   = r_fill + 1'b1;
            end
        end else begin
            if (w_empty) begin
                n_out_data.status = STATUS_REMOVE_EMPTY;
            end else begin
                w_cmd.op             = w_accept ? OP_REMOVE : OP_HOLD;
                n_fill               = r_fill - 1'b1;
                n_out_data.out_value = w_link[0].value;
                n_out_data.out_prio  = w_link[0].prio;
            end
        end
        n_out_data.count    = COUNT_W'(n_fill);
        n_out_data.is_empty = (n_fill == '0);
        n_out_data.is_full  = (n_fill == FILL_W'(DEPTH));
    end

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        t_link w_prev;
        t_link w_next;

        if (gi == 0) begin : g_head
            // The head cell always sees "ahead is higher", so when it gives way it takes the new entry.
            assign w_prev = '{value: '0, prio: '0, ge: 1'b1};
        end else begin : g_body
            assign w_prev = w_link[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_tail
            assign w_next = w_link[gi];
        end else begin : g_inner
            assign w_next = w_link[gi+1];
        end

        spq_cell u_cell (
            .i_clk      (i_clk),
            .i_cmd      (w_cmd),
            .i_occupied (r_fill > FILL_W'(gi)),
            .i_prev     (w_prev),
            .i_next     (w_next),
            .o_link     (w_link[gi])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_fill      <= n_fill;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

[hw/rtl/spq_cell.sv]
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: keeps its entry, takes the new entry, or
// takes a neighbor's entry as the chain shifts.
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic          i_clk,
    input  spq_pkg::t_cmd  i_cmd,
    input  logic          i_occupied,
    input  spq_pkg::t_link i_prev,
    input  spq_pkg::t_link i_next,
    output spq_pkg::t_link o_link
);
    import spq_pkg::*;

    logic signed [VALUE_W-1:0] r_value;
    logic        [PRIO_W-1:0]  r_prio;
    logic signed [VALUE_W-1:0] n_value;
    logic        [PRIO_W-1:0]  n_prio;
    logic                      w_ge;

    // An entry with equal or higher priority stays ahead of the new one.
    assign w_ge   = i_occupied && (r_prio >= i_cmd.prio);
    assign o_link = '{value: r_value, prio: r_prio, ge: w_ge};

    always_comb begin
        n_value = r_value;
        n_prio  = r_prio;
        case (i_cmd.op)
            OP_INSERT: begin
                if (!w_ge) begin
                    if (i_prev.ge) begin
                        n_value = i_cmd.value;
                        n_prio  = i_cmd.prio;
                    end else begin
                        n_value = i_prev.value;
                        n_prio  = i_prev.prio;
                    end
                end
            end
            OP_REMOVE: begin
                n_value = i_next.value;
                n_prio  = i_next.prio;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_prio  <= n_prio;
    end

endmodule

[hw/rtl/spq_checker.sv]
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks on the sorted priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_macros.svh"

module spq_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input spq_pkg::t_out o_out_data
);
    import spq_pkg::*;

    logic w_in_accept;
    logic w_out_stalled;
    logic w_empty_ok;
    logic w_reject;
    logic w_reject_zero;
    logic w_reject_flags;

    assign w_in_accept    = i_in_valid && o_in_ready;
    assign w_out_stalled  = o_out_valid && !i_out_ready;
    assign w_empty_ok     = (o_out_data.count == '0) && !o_out_data.is_full;
    assign w_reject       = o_out_valid && (o_out_data.status != STATUS_DONE);
    assign w_reject_zero  = (o_out_data.out_value == '0) && (o_out_data.out_prio == '0);
    assign w_reject_flags = (o_out_data.status == STATUS_INSERT_FULL && o_out_data.is_full)
                         || (o_out_data.status == STATUS_REMOVE_EMPTY && o_out_data.is_empty);

    // Every accepted transaction shows up as a result in the next cycle.
    `SPQ_ASSERT_NEXT(a_accept_result, w_in_accept, o_out_valid)

    // A stalled result must hold.
    `SPQ_ASSERT_NEXT(a_out_hold, w_out_stalled, o_out_valid && $stable(o_out_data))

    // An empty queue reports a zero count and is never full.
    `SPQ_ASSERT_NOW(a_empty_flags, o_out_valid && o_out_data.is_empty, w_empty_ok)

    // A rejected transaction returns no entry.
    `SPQ_ASSERT_NOW(a_reject_zero, w_reject, w_reject_zero)

    // A full rejection leaves the queue full, an empty rejection leaves it empty.
    `SPQ_ASSERT_NOW(a_reject_flags, w_reject, w_reject_flags)

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);

[tb/tb_sorted_priority_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue
// Drives insert and remove transactions into the sorted priority queue and
// checks every result against an in-bench model of the sorted array, under
// random idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue;
    import spq_pkg::*;

    localparam int RANDOM_ITEMS = 480;
    localparam int LONG_STALL   = 120;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_LIMIT  = 2000;
    localparam int PRINT_LIMIT  = 100;

    typedef enum logic [1:0] {BURST_FILL, BURST_DRAIN, BURST_MIXED} t_burst;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_in  i_in_data;
    logic o_out_valid;
    logic i_out_ready;
    t_out o_out_data;

    sorted_priority_queue dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    t_in  items_to_send[$];
    t_out pending_results[$];
    int   total_items;
    int   accepted_count;
    int   checked_count;
    int   mismatch_count;
    int   cycle_count;
    int   stall_left;
    bit   stall_done;
    bit   item_taken;

    // Model of the held entries, front of the queue at index zero.
    logic signed [VALUE_W-1:0] held_value [DEPTH];
    logic        [PRIO_W-1:0]  held_prio  [DEPTH];
    int                        held_count;
    int                        inserts_done;
    int                        inserts_full;
    int                        removes_done;
    int                        removes_empty;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_out predict_queue_result(t_in item);
        t_out res;
        int   slot;
        res = '0;
        res.status = STATUS_DONE;
        if (item.mode == MODE_INSERT) begin
            if (held_count >= DEPTH) begin
                res.status = STATUS_INSERT_FULL;
                inserts_full++;
            end else begin
                // New entry goes behind everything of equal or higher priority.
                slot = held_count;
                while (slot > 0 && held_prio[slot-1] < item.prio) begin
                    held_value[slot] = held_value[slot-1];
                    held_prio[slot]  = held_prio[slot-1];
                    slot--;
                end
                held_value[slot] = item.value;
                held_prio[slot]  = item.prio;
                held_count++;
                inserts_done++;
            end
        end else begin
            if (held_count == 0) begin
                res.status = STATUS_REMOVE_EMPTY;
                removes_empty++;
            end else begin
                res.out_value = held_value[0];
                res.out_prio  = held_prio[0];
                for (int i = 1; i < held_count; i++) begin
                    held_value[i-1] = held_value[i];
                    held_prio[i-1]  = held_prio[i];
                end
                held_count--;
                removes_done++;
            end
        end
        res.count    = COUNT_W'(held_count);
        res.is_empty = (held_count == 0);
        res.is_full  = (held_count == DEPTH);
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT) begin
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        end
    endtask

    task automatic add_item(logic mode, int value, int prio);
        t_in item;
        item.mode  = mode;
        item.value = VALUE_W'(value);
        item.prio  = PRIO_W'(prio);
        items_to_send.push_back(item);
    endtask

    function automatic int sender_idle_pct();
        int phase;
        phase = accepted_count * 3 / total_items;
        if (phase == 0) begin
            return 23;
        end else if (phase == 1) begin
            return 67;
        end
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        int phase;
        phase = accepted_count * 3 / total_items;
        if (phase == 0) begin
            return 67;
        end else if (phase == 1) begin
            return 23;
        end
        return 0;
    endfunction

    // Input driver: presents the front of the send queue until it is taken.
    always @(negedge i_clk) begin : drive_input
        logic offer;
        offer = i_in_valid;
        if (i_rst_n) begin
            if (item_taken) begin
                void'(items_to_send.pop_front());
                item_taken = 1'b0;
                offer = 1'b0;
            end
            if (!offer && items_to_send.size() != 0
                    && $urandom_range(99) >= sender_idle_pct()) begin
                offer = 1'b1;
            end
            i_in_valid <= offer;
            if (offer) begin
                i_in_data <= items_to_send[0];
            end
        end
    end

    // Output ready, with one long hold-off late in the run so the block backs up.
    always @(negedge i_clk) begin : drive_output_ready
        if (i_rst_n) begin
            if (stall_left != 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (!stall_done && accepted_count >= total_items - 60) begin
                stall_done = 1'b1;
                stall_left = LONG_STALL - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= receiver_idle_pct());
            end
        end
    end

    // Monitor: checks each completed result, then records the accepted transaction.
    always @(posedge i_clk) begin : watch_ports
        t_out want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result with nothing expected, status",
                                    int'(o_out_data.status), 0);
                end else begin
                    want = pending_results.pop_front();
                    checked_count++;
                    if (o_out_data.status !== want.status)
                        report_mismatch("status", int'(o_out_data.status), int'(want.status));
                    if (o_out_data.out_value !== want.out_value)
                        report_mismatch("out_value", int'($signed(o_out_data.out_value)),
                                        int'($signed(want.out_value)));
                    if (o_out_data.out_prio !== want.out_prio)
                        report_mismatch("out_prio", int'(o_out_data.out_prio),
                                        int'(want.out_prio));
                    if (o_out_data.count !== want.count)
                        report_mismatch("count", int'(o_out_data.count), int'(want.count));
                    if (o_out_data.is_empty !== want.is_empty)
                        report_mismatch("is_empty", int'(o_out_data.is_empty),
                                        int'(want.is_empty));
                    if (o_out_data.is_full !== want.is_full)
                        report_mismatch("is_full", int'(o_out_data.is_full),
                                        int'(want.is_full));
                end
            end
            if (i_in_valid && o_in_ready) begin
                pending_results.push_back(predict_queue_result(i_in_data));
                accepted_count++;
                item_taken = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin : run_test
        t_burst kind;
        int     made;
        int     burst_len;
        int     insert_pct;
        int     prio_base;
        int     value;
        bit     narrow;
        int     waited;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_ready = 1'b0;
        held_count  = 0;

        // Directed part: remove on empty, extremes, equal priorities, insert on full.
        add_item(MODE_REMOVE, 32767, 15);
        add_item(MODE_INSERT, -32768, 0);
        add_item(MODE_INSERT, 32767, 15);
        add_item(MODE_INSERT, 0, 7);
        add_item(MODE_INSERT, 1, 5);
        add_item(MODE_INSERT, 2, 5);
        add_item(MODE_INSERT, 3, 5);
        add_item(MODE_INSERT, -1, 15);
        add_item(MODE_INSERT, 100, 0);
        add_item(MODE_INSERT, -100, 8);
        add_item(MODE_INSERT, 5, 5);
        add_item(MODE_INSERT, 16'h5555, 10);
        add_item(MODE_INSERT, 16'hAAAA, 10);
        add_item(MODE_INSERT, 7, 1);
        add_item(MODE_INSERT, 8, 14);
        add_item(MODE_INSERT, 9, 3);
        add_item(MODE_INSERT, 10, 5);
        add_item(MODE_INSERT, 11, 15);
        add_item(MODE_REMOVE, -1, 0);
        add_item(MODE_REMOVE, 0, 15);
        add_item(MODE_REMOVE, 16'h5A5A, 6);
        add_item(MODE_REMOVE, 16'hA5A5, 9);

        // Random part in bursts that drive the queue to full, to empty, or hold it midway.
        made = 0;
        while (made < RANDOM_ITEMS) begin
            kind      = t_burst'($urandom_range(2));
            burst_len = $urandom_range(6, 36);
            narrow    = $urandom_range(1);
            prio_base = $urandom_range(15);
            case (kind)
                BURST_FILL:  insert_pct = 85;
                BURST_DRAIN: insert_pct = 15;
                default:     insert_pct = 50;
            endcase
            for (int k = 0; k < burst_len && made < RANDOM_ITEMS; k++) begin
                if ($urandom_range(9) == 0) begin
                    value = ($urandom_range(1) != 0) ? 32767 : -32768;
                end else begin
                    value = $urandom;
                end
                add_item(($urandom_range(99) < insert_pct) ? MODE_INSERT : MODE_REMOVE,
                         value,
                         narrow ? (prio_base ^ $urandom_range(1)) : $urandom_range(15));
                made++;
            end
        end
        total_items = items_to_send.size();

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait (accepted_count == total_items);
        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (4) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            report_mismatch("results never delivered", 0, pending_results.size());
        end

        $display("covered %0d transactions: %0d inserts stored, %0d refused as full,",
                 accepted_count, inserts_done, inserts_full);
        $display("%0d removes served, %0d refused as empty; %0d results checked",
                 removes_done, removes_empty, checked_count);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/spq_pkg.sv
hw/rtl/spq_cell.sv
hw/rtl/sorted_priority_queue.sv
hw/rtl/spq_checker.sv
tb/tb_sorted_priority_queue.sv
